// ----- design/bmsmrd_pkg.sv -----
// ============================================================================
// bmsmrd_pkg: shared types and constants of the response decoder
// Header codes, frame lengths, result kinds, register indexes and the
// structs passed between the front end, the job queue and the back end.
// ============================================================================
package bmsmrd_pkg;

    localparam int CELL_COUNT_DEF  = 16;
    localparam int PROBE_COUNT_DEF = 4;
    localparam int MAX_CELLS       = 16;
    localparam int MAX_PROBES      = 4;

    localparam int RAM_WIDTH = 8;
    localparam int RAM_DEPTH = 128;
    localparam int RAM_AW    = 7;

    localparam logic [7:0] HDR_ADDR_A    = 8'h01;
    localparam logic [7:0] HDR_ADDR_B    = 8'h02;
    localparam logic [7:0] HDR_FUNC_READ = 8'h04;
    localparam logic [7:0] HDR_LEN_LONG  = 8'h34;
    localparam logic [7:0] HDR_LEN_SHORT = 8'h24;

    localparam logic [5:0] POS_LONG  = 6'd52;
    localparam logic [5:0] POS_SHORT = 6'd36;

    localparam logic [16:0] KELVIN_OFFSET = 17'd2731;

    localparam int SLOT_W = 5;
    localparam logic [SLOT_W-1:0] LONG_SLOTS   = 5'd20;
    localparam logic [SLOT_W-1:0] SHORT_SLOTS  = 5'd3;
    localparam logic [SLOT_W-1:0] PROBE_SLOT0  = 5'd16;
    localparam logic [SLOT_W-1:0] SLOT_PACK_V  = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_CURRENT = 5'd1;
    localparam logic [SLOT_W-1:0] SLOT_SOC     = 5'd2;

    localparam logic [5:0] OFF_PACK_V  = 6'd0;
    localparam logic [5:0] OFF_CURRENT = 6'd2;
    localparam logic [5:0] OFF_SOC     = 6'd34;

    typedef enum logic [1:0] {
        CFG_OWN_ADDR,
        CFG_CELL_MASK,
        CFG_PROBE_MASK,
        CFG_PACK_MASK
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_CELL,
        KIND_TEMP,
        KIND_PACK_V,
        KIND_CURRENT,
        KIND_SOC
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_RD_LO,
        BK_CALC
    } t_back_state;

    typedef struct packed {
        logic bank;
        logic long_frame;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic en;
        logic bank;
    } t_done;

    typedef struct packed {
        logic [1:0]  own_address;
        logic [15:0] cell_mask;
        logic [3:0]  probe_mask;
        logic [2:0]  pack_mask;
    } t_cfg;

endpackage

// ----- design/bmsmrd_in_if.sv -----
// ============================================================================
// bmsmrd_in_if: received byte channel
// Valid/ready channel carrying one serial byte per word.
// ============================================================================
interface bmsmrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- design/bmsmrd_out_if.sv -----
// ============================================================================
// bmsmrd_out_if: decoded result channel
// Valid/ready channel carrying one decoded quantity per word.
// ============================================================================
interface bmsmrd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [3:0]         channel;
    logic signed [16:0] value;
    logic               last;

    modport source (output valid, output kind, output channel, output value,
                    output last, input ready);
    modport sink   (input valid, input kind, input channel, input value,
                    input last, output ready);
endinterface

// ----- design/bmsmrd_ram.sv -----
// ============================================================================
// bmsmrd_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module bmsmrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/bmsmrd_front.sv -----
// ============================================================================
// bmsmrd_front: header hunter and payload collector
// Slides a two-byte window over the byte stream, locks on a response
// header, writes the payload into one of two RAM banks and queues a job
// for each completed frame of the own address.
// ============================================================================
module bmsmrd_front
    import bmsmrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmsmrd_in_if.sink   i_in,
    input  logic [1:0]  i_own_address,
    input  t_done       i_done,
    output t_ram_wr     o_wr,
    output logic        o_push,
    output t_job        o_job
);
    logic [7:0] r_win0;
    logic [7:0] r_win1;
    logic [1:0] r_fill;
    logic       r_collect;
    logic       r_long;
    logic       r_match;
    logic [5:0] r_pos;
    logic       r_bank;
    logic [1:0] r_busy;

    logic [5:0] len;
    logic       wr_needed;
    logic       frame_end;
    logic       header_hit;
    logic       accept;
    logic [7:0] rx;
    logic [1:0] set_vec;
    logic [1:0] clr_vec;

    assign rx         = i_in.rx_byte;
    assign len        = r_long ? POS_LONG : POS_SHORT;
    assign wr_needed  = r_collect && (r_pos < len);
    assign frame_end  = r_collect && (r_pos > len);
    assign i_in.ready = !(wr_needed && r_busy[r_bank]);
    assign accept     = i_in.valid && i_in.ready;
    assign header_hit = !r_collect && (r_fill == 2'd2)
                        && ((r_win0 == HDR_ADDR_A) || (r_win0 == HDR_ADDR_B))
                        && (r_win1 == HDR_FUNC_READ)
                        && ((rx == HDR_LEN_LONG) || (rx == HDR_LEN_SHORT));

    assign o_wr.en   = accept && wr_needed;
    assign o_wr.addr = {r_bank, r_pos};
    assign o_wr.data = rx;
    assign o_push    = accept && frame_end && r_match;
    assign o_job     = '{bank: r_bank, long_frame: r_long};

    assign set_vec = o_push ? (2'b01 << r_bank) : 2'b00;
    assign clr_vec = i_done.en ? (2'b01 << i_done.bank) : 2'b00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= 2'd0;
            r_collect <= 1'b0;
            r_long    <= 1'b0;
            r_match   <= 1'b0;
            r_pos     <= 6'd0;
            r_bank    <= 1'b0;
            r_busy    <= 2'b00;
        end else begin
            r_busy <= (r_busy | set_vec) & ~clr_vec;
            if (accept) begin
                if (r_collect) begin
                    if (frame_end) begin
                        r_collect <= 1'b0;
                        r_pos     <= 6'd0;
                        r_fill    <= 2'd0;
                        if (r_match) begin
                            r_bank <= !r_bank;
                        end
                    end else begin
                        r_pos <= r_pos + 6'd1;
                    end
                end else if (header_hit) begin
                    r_collect <= 1'b1;
                    r_long    <= (rx == HDR_LEN_LONG);
                    r_match   <= (r_win0 == {6'd0, i_own_address});
                    r_pos     <= 6'd0;
                    r_fill    <= 2'd0;
                end else if (r_fill != 2'd2) begin
                    r_fill <= r_fill + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_collect && !header_hit) begin
            priority if (r_fill == 2'd0) begin
                r_win0 <= rx;
            end else if (r_fill == 2'd1) begin
                r_win1 <= rx;
            end else begin
                r_win0 <= r_win1;
                r_win1 <= rx;
            end
        end
    end
endmodule

// ----- design/bmsmrd_fifo.sv -----
// ============================================================================
// bmsmrd_fifo: two-entry frame job queue
// Holds completed frames between the front end and the back end.
// ============================================================================
module bmsmrd_fifo
    import bmsmrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic o_full
);
    t_job       r_entry [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_job   = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_job;
        end
    end
endmodule

// ----- design/bmsmrd_back.sv -----
// ============================================================================
// bmsmrd_back: result sequencer
// Walks the result slots of a queued frame, reads each enabled field from
// the payload RAM as a high byte and then a low byte, decodes it and hands
// it to the output register.
// ============================================================================
module bmsmrd_back
    import bmsmrd_pkg::*;
#(
    parameter int CELL_COUNT  = CELL_COUNT_DEF,
    parameter int PROBE_COUNT = PROBE_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_rd_en,
    output logic [RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]        i_rdata,
    output t_done             o_done,
    bmsmrd_out_if.source      o_out
);
    t_back_state             r_state;
    t_back_state             n_state;
    t_job                    r_job;
    logic [SLOT_W-1:0]       r_slot;
    logic [7:0]              r_hi;
    logic                    r_ovalid;
    t_kind                   r_kind;
    logic [3:0]              r_chan;
    logic [16:0]             r_value;
    logic                    r_last;

    logic [19:0]             long_vec;
    logic [19:0]             act_vec;
    logic [SLOT_W-1:0]       end_slot;
    logic                    past_end;
    logic                    slot_en;
    logic                    slot_last;
    logic [5:0]              offset;
    logic                    out_free;
    logic                    load_job;
    logic                    slot_inc;
    logic                    hi_cap;
    logic                    load_out;
    logic                    rd_lo;
    logic [15:0]             raw;
    t_kind                   kind_c;
    logic [3:0]              chan_c;
    logic [16:0]             value_c;

    always_comb begin
        long_vec = '0;
        for (int c = 0; c < MAX_CELLS; c++) begin
            long_vec[c] = i_cfg.cell_mask[c] && (c < CELL_COUNT);
        end
        for (int t = 0; t < MAX_PROBES; t++) begin
            long_vec[MAX_CELLS + t] = i_cfg.probe_mask[t] && (t < PROBE_COUNT);
        end
    end

    assign act_vec   = r_job.long_frame ? long_vec : {17'd0, i_cfg.pack_mask};
    assign end_slot  = r_job.long_frame ? LONG_SLOTS : SHORT_SLOTS;
    assign past_end  = (r_slot >= end_slot);
    assign slot_en   = !past_end && act_vec[r_slot];
    assign slot_last = ((act_vec >> (r_slot + 5'd1)) == 20'd0);
    assign out_free  = !r_ovalid || o_out.ready;

    always_comb begin
        if (r_job.long_frame) begin
            offset = {r_slot, 1'b0};
        end else begin
            unique case (r_slot)
                SLOT_PACK_V:  offset = OFF_PACK_V;
                SLOT_CURRENT: offset = OFF_CURRENT;
                default:      offset = OFF_SOC;
            endcase
        end
    end

    assign o_rd_addr = {r_job.bank, rd_lo ? (offset + 6'd1) : offset};

    assign raw = {r_hi, i_rdata};
    always_comb begin
        chan_c  = 4'd0;
        value_c = {1'b0, raw};
        if (r_job.long_frame) begin
            if (r_slot < PROBE_SLOT0) begin
                kind_c = KIND_CELL;
                chan_c = r_slot[3:0];
            end else begin
                kind_c  = KIND_TEMP;
                chan_c  = 4'(r_slot - PROBE_SLOT0);
                value_c = {1'b0, raw} - KELVIN_OFFSET;
            end
        end else begin
            unique case (r_slot)
                SLOT_PACK_V: kind_c = KIND_PACK_V;
                SLOT_CURRENT: begin
                    kind_c  = KIND_CURRENT;
                    value_c = {raw[15], raw};
                end
                default: kind_c = KIND_SOC;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                priority if (past_end) begin
                    n_state = BK_IDLE;
                end else if (slot_en) begin
                    n_state = BK_RD_LO;
                end
            end
            BK_RD_LO: n_state = BK_CALC;
            BK_CALC: begin
                if (out_free) begin
                    n_state = BK_SCAN;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        load_job     = 1'b0;
        slot_inc     = 1'b0;
        hi_cap       = 1'b0;
        load_out     = 1'b0;
        rd_lo        = 1'b0;
        o_rd_en      = 1'b0;
        o_done.en    = 1'b0;
        o_done.bank  = r_job.bank;
        unique case (r_state)
            BK_IDLE: load_job = i_valid;
            BK_SCAN: begin
                priority if (past_end) begin
                    o_done.en = 1'b1;
                end else if (slot_en) begin
                    o_rd_en = 1'b1;
                end else begin
                    slot_inc = 1'b1;
                end
            end
            BK_RD_LO: begin
                hi_cap  = 1'b1;
                rd_lo   = 1'b1;
                o_rd_en = 1'b1;
            end
            BK_CALC: begin
                load_out = out_free;
                slot_inc = out_free;
            end
            default: ;
        endcase
    end

    assign o_pop = load_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_job) begin
            r_job  <= i_job;
            r_slot <= '0;
        end else if (slot_inc) begin
            r_slot <= r_slot + 5'd1;
        end
        if (hi_cap) begin
            r_hi <= i_rdata;
        end
        if (load_out) begin
            r_kind  <= kind_c;
            r_chan  <= chan_c;
            r_value <= value_c;
            r_last  <= slot_last;
        end
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.kind    = r_kind;
    assign o_out.channel = r_chan;
    assign o_out.value   = r_value;
    assign o_out.last    = r_last;
endmodule

// ----- design/bms_modbus_response_decoder_unit.sv -----
// ============================================================================
// bms_modbus_response_decoder_unit: read-input-registers response decoder
// Parses received bytes into frames and emits the enabled decoded fields.
// ============================================================================
// Payload bytes go into one of two RAM banks, and each finished frame of
// the own address is queued. The result sequencer takes a job from the
// queue, then passes over every result slot it skips in the scan state
// and steps every slot it reports through the scan, low-byte read and
// calc states, bound by the single read port of the payload RAM. A last
// scan step releases the bank. The calc state waits while the output
// is stalled.
// Byte intake holds off only when a new frame's payload would land in a
// bank whose results are still being read out. The CRC is not checked and
// frames for the other address yield nothing.
// ============================================================================
module bms_modbus_response_decoder_unit
    import bmsmrd_pkg::*;
#(
    parameter int CELL_COUNT  = CELL_COUNT_DEF,
    parameter int PROBE_COUNT = PROBE_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmsmrd_in_if.sink    i_in,
    bmsmrd_out_if.source o_out,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    t_cfg              r_cfg;
    t_ram_wr           ram_wr;
    logic              push;
    t_job              push_job;
    logic              pop;
    logic              q_valid;
    t_job              q_job;
    logic              q_full;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rdata;
    t_done             done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address <= 2'd1;
            r_cfg.cell_mask   <= 16'hFFFF;
            r_cfg.probe_mask  <= 4'hF;
            r_cfg.pack_mask   <= 3'h7;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_OWN_ADDR:   r_cfg.own_address <= i_cfg_data[1:0];
                CFG_CELL_MASK:  r_cfg.cell_mask   <= i_cfg_data;
                CFG_PROBE_MASK: r_cfg.probe_mask  <= i_cfg_data[3:0];
                CFG_PACK_MASK:  r_cfg.pack_mask   <= i_cfg_data[2:0];
            endcase
        end
    end

    bmsmrd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_own_address (r_cfg.own_address),
        .i_done        (done),
        .o_wr          (ram_wr),
        .o_push        (push),
        .o_job         (push_job)
    );

    bmsmrd_ram #(
        .WIDTH (RAM_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.en),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    bmsmrd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_full  (q_full)
    );

    bmsmrd_back #(
        .CELL_COUNT  (CELL_COUNT),
        .PROBE_COUNT (PROBE_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (q_valid),
        .i_job     (q_job),
        .o_pop     (pop),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rdata   (rdata),
        .o_done    (done),
        .o_out     (o_out)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("job pushed into full queue");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("job popped from empty queue");

    a_hunt_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !ram_wr.en)
        else $error("payload write right after frame end");

    a_done_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done.en |-> !rd_en)
        else $error("payload read while releasing bank");
`endif
endmodule
